// File: design/pfa_pkg.sv
// page frame allocator package: map geometry, field widths and codes
// used by the allocator core, its checker and its scoreboard
`default_nettype none

package pfa_pkg;

   localparam int MAX_PAGES  = 4096;
   localparam int IDX_LIMIT  = 4096;
   localparam int PAGES_USED = (MAX_PAGES < IDX_LIMIT) ? MAX_PAGES : IDX_LIMIT;

   localparam int PAGE_W  = 12;
   localparam int COUNT_W = 13;
   localparam int WORD_W  = 64;
   localparam int ROW_N   = PAGES_USED / WORD_W;
   localparam int ROW_W   = $clog2(ROW_N);
   localparam int BIT_W   = $clog2(WORD_W);

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] LIMIT_PAGES = COUNT_W'(PAGES_USED);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic CSR_FIRST = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NO_FREE      = 2'd1;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

endpackage

`default_nettype wire

// File: design/page_frame_allocator_core.sv
// page frame allocator core: first-fit bitmap allocator with a word-wide search unit
// depends on pfa_pkg and pfa_ram
//
// usage
//   request channel: req_cmd and req_page_index are taken at a rising edge with start
//   high and busy low. cmd allocate scans the used map upward from first_alloc_page,
//   cmd free clears the used bit of req_page_index.
//   response channel: rsp_valid is high for exactly one cycle with rsp_alloc_index,
//   rsp_status and rsp_avail_pages; the receiver cannot stall, so a response is never
//   held and a new request may be started in the cycle the strobe is shown.
//   csr port: csr_we writes csr_wdata to register csr_index (0 first_alloc_page,
//   1 page_count) at once; write only while busy is low and no response is pending.
// timing
//   the map is a 64 x 64-bit ram searched one word per cycle by one shared
//   find-first-zero unit. allocate: words read in S_ALLOC_EV up to a free page or
//   the last row, then S_DONE. free in range: S_FREE_EV, then S_DONE. out-of-range
//   free or empty window: S_DONE only. busy is high from the transfer until the strobe.
// reset
//   synchronous reset clears per-row valid bits, so the whole map reads free at once;
//   no clearing pass is needed. registers return to 0 and 4096, used count to zero.
`default_nettype none

module page_frame_allocator_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_cmd,
   input  wire logic [pfa_pkg::PAGE_W-1:0]  req_page_index,
   output logic                             rsp_valid,
   output logic      [pfa_pkg::PAGE_W-1:0]  rsp_alloc_index,
   output logic      [1:0]                  rsp_status,
   output logic      [pfa_pkg::COUNT_W-1:0] rsp_avail_pages,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [pfa_pkg::COUNT_W-1:0] csr_wdata
);

   import pfa_pkg::*;

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_ALLOC_EV = 2'd1;
   localparam logic [1:0] S_FREE_EV  = 2'd2;
   localparam logic [1:0] S_DONE     = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [PAGE_W-1:0]  first_ff, first_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [ROW_N-1:0]   row_valid_ff, row_valid_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [PAGE_W-1:0]  grant_ff, grant_in;
   logic [1:0]         status_ff, status_in;

   logic               rsp_valid_ff;
   logic [PAGE_W-1:0]  rsp_index_ff;
   logic [1:0]         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_free_ff;

   logic [COUNT_W-1:0] lim;
   logic [COUNT_W-1:0] last_page;
   logic [COUNT_W-1:0] win_size;
   logic [COUNT_W-1:0] free_left;
   logic               win_empty;
   logic [ROW_W-1:0]   first_row, last_row, req_row;
   logic [BIT_W-1:0]   first_bit, last_bit, req_bit;

   logic               ram_we;
   logic [ROW_W-1:0]   ram_waddr, ram_raddr;
   word_type           ram_wdata, ram_rdata;
   word_type           cur_word, lo_mask, hi_mask, avail, lowbit;
   logic [BIT_W-1:0]   enc;
   logic               found;
   logic               accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign lim       = (count_ff < LIMIT_PAGES) ? count_ff : LIMIT_PAGES;
   assign win_empty = ({1'b0, first_ff} >= lim);
   assign last_page = lim - COUNT_W'(1);
   assign win_size  = lim - {1'b0, first_ff};
   assign free_left = (win_empty || (used_ff >= win_size)) ? '0 : (win_size - used_ff);

   assign first_row = first_ff[BIT_W +: ROW_W];
   assign first_bit = first_ff[BIT_W-1:0];
   assign last_row  = last_page[BIT_W +: ROW_W];
   assign last_bit  = last_page[BIT_W-1:0];
   assign req_row   = req_page_index[BIT_W +: ROW_W];
   assign req_bit   = req_page_index[BIT_W-1:0];

   always_comb begin
      unique case (state_ff)
         S_IDLE:     ram_raddr = (req_cmd == CMD_ALLOC) ? first_row : req_row;
         S_ALLOC_EV: ram_raddr = row_ff + ROW_W'(1);
         default:    ram_raddr = row_ff;
      endcase
   end

   pfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROW_N)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // find-first-free unit
   assign cur_word = row_valid_ff[row_ff] ? ram_rdata : '0;
   assign lo_mask  = (row_ff == first_row) ? ({WORD_W{1'b1}} << first_bit) : {WORD_W{1'b1}};
   assign hi_mask  = (row_ff == last_row) ?
                     ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit)) : {WORD_W{1'b1}};
   assign avail    = ~cur_word & lo_mask & hi_mask;
   assign lowbit   = avail & (~avail + word_type'(1));
   assign found    = |avail;

   always_comb begin
      enc = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (lowbit[i]) begin
            enc = enc | BIT_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      row_valid_in = row_valid_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      grant_in     = grant_ff;
      status_in    = status_ff;
      ram_we       = 1'b0;
      ram_waddr    = row_ff;
      ram_wdata    = cur_word;

      if (csr_we) begin
         if (csr_index == CSR_FIRST) begin
            first_in = csr_wdata[PAGE_W-1:0];
         end else begin
            count_in = csr_wdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               grant_in = '0;
               bit_in   = req_bit;
               if (req_cmd == CMD_ALLOC) begin
                  row_in = first_row;
                  if (win_empty) begin
                     status_in = ST_NO_FREE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_ALLOC_EV;
                  end
               end else begin
                  row_in = req_row;
                  if ((req_page_index < first_ff) || ({1'b0, req_page_index} >= lim)) begin
                     status_in = ST_OUT_OF_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_FREE_EV;
                  end
               end
            end
         end
         S_ALLOC_EV: begin
            if (found) begin
               ram_we               = 1'b1;
               ram_wdata            = cur_word | lowbit;
               row_valid_in[row_ff] = 1'b1;
               grant_in             = {row_ff, enc};
               status_in            = ST_OK;
               if (used_ff != COUNT_MAX) begin
                  used_in = used_ff + COUNT_W'(1);
               end
               state_in = S_DONE;
            end else if (row_ff == last_row) begin
               status_in = ST_NO_FREE;
               state_in  = S_DONE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_FREE_EV: begin
            if (cur_word[bit_ff]) begin
               ram_we               = 1'b1;
               ram_wdata            = cur_word & ~(word_type'(1) << bit_ff);
               row_valid_in[row_ff] = 1'b1;
               status_in            = ST_OK;
               if (used_ff != '0) begin
                  used_in = used_ff - COUNT_W'(1);
               end
            end else begin
               status_in = ST_ALREADY_FREE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         count_ff     <= COUNT_W'(IDX_LIMIT);
         used_ff      <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= (state_ff == S_DONE);
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      bit_ff    <= bit_in;
      grant_ff  <= grant_in;
      status_ff <= status_in;
      if (state_ff == S_DONE) begin
         rsp_index_ff  <= grant_ff;
         rsp_status_ff <= status_ff;
         rsp_free_ff   <= free_left;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_avail_pages = rsp_free_ff;

endmodule

`default_nettype wire

// File: design/pfa_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/pfa_checker.sv
// port-level checker for the page frame allocator core, bound to page_frame_allocator_core
// depends on pfa_pkg and page_frame_allocator_core
`default_nettype none

module pfa_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [pfa_pkg::PAGE_W-1:0]  rsp_alloc_index,
   input wire logic [1:0]                  rsp_status,
   input wire logic [pfa_pkg::COUNT_W-1:0] rsp_avail_pages
);

   import pfa_pkg::*;

   // the core reports busy after every request transfer
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after request transfer");

   a_idle_at_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_alloc_index == '0))
      else $error("nonzero index on failed request");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_avail_pages <= COUNT_W'(PAGES_USED)))
      else $error("free page count above map size");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);

`default_nettype wire

// File: dv/pfa_sb_pkg.sv
// scoreboard for the page frame allocator: first-fit used-map model and response check
// depends on pfa_pkg for widths, map size and status codes
package pfa_sb_pkg;
   import pfa_pkg::*;

   typedef struct packed {
      logic [PAGE_W-1:0]  alloc_index;
      logic [1:0]         status;
      logic [COUNT_W-1:0] avail_pages;
   } frame_reply_type;

   class frame_board_type;
      bit                 used_map [PAGES_USED];
      logic [COUNT_W-1:0] used_count;
      logic [PAGE_W-1:0]  first_page;
      logic [COUNT_W-1:0] page_count;
      frame_reply_type    replies_due [$];
      int                 mismatches;

      function new();
         foreach (used_map[i]) used_map[i] = 1'b0;
         used_count = '0;
         first_page = '0;
         page_count = LIMIT_PAGES;
         mismatches = 0;
      endfunction

      function int page_limit();
         return (int'(page_count) > PAGES_USED) ? PAGES_USED : int'(page_count);
      endfunction

      function logic [COUNT_W-1:0] pages_left();
         int lim;
         int span;
         lim = page_limit();
         if (int'(first_page) >= lim) return '0;
         span = lim - int'(first_page);
         if (int'(used_count) >= span) return '0;
         return COUNT_W'(span - int'(used_count));
      endfunction

      function void set_register(logic idx, logic [COUNT_W-1:0] value);
         if (idx == CSR_FIRST) first_page = value[PAGE_W-1:0];
         else page_count = value;
      endfunction

      function void note_request(logic cmd, logic [PAGE_W-1:0] idx);
         frame_reply_type r;
         int              lim;
         bit              found;
         lim = page_limit();
         r.alloc_index = '0;
         r.status = ST_OK;
         found = 1'b0;
         if (cmd == CMD_ALLOC) begin
            for (int p = int'(first_page); p < lim && !found; p++) begin
               if (!used_map[p]) begin
                  used_map[p] = 1'b1;
                  if (used_count != COUNT_MAX) used_count++;
                  r.alloc_index = PAGE_W'(p);
                  found = 1'b1;
               end
            end
            if (!found) r.status = ST_NO_FREE;
         end else if (int'(idx) < int'(first_page) || int'(idx) >= lim) begin
            r.status = ST_OUT_OF_RANGE;
         end else if (!used_map[idx]) begin
            r.status = ST_ALREADY_FREE;
         end else begin
            used_map[idx] = 1'b0;
            if (used_count != '0) used_count--;
         end
         r.avail_pages = pages_left();
         replies_due.push_back(r);
      endfunction

      function void check_response(logic [PAGE_W-1:0] alloc_index, logic [1:0] status,
                                   logic [COUNT_W-1:0] avail_pages);
         frame_reply_type want;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: index %0d status %0d free %0d",
                        alloc_index, status, avail_pages);
            return;
         end
         want = replies_due.pop_front();
         if (want.alloc_index !== alloc_index || want.status !== status ||
             want.avail_pages !== avail_pages) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response mismatch: expected index %0d status %0d free %0d,",
                         " got index %0d status %0d free %0d"},
                        want.alloc_index, want.status, want.avail_pages,
                        alloc_index, status, avail_pages);
         end
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass
endpackage

// File: dv/tb_page_frame_allocator_core.sv
// testbench for page_frame_allocator_core: directed and random allocate/free traffic
// across many window settings, every response checked against a first-fit map model
// depends on pfa_pkg and pfa_sb_pkg
module tb_page_frame_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pfa_pkg::*;
   import pfa_sb_pkg::*;

   localparam int ITEM_TARGET = 2000;
   localparam int STALL_LIMIT = 5000;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic                req_cmd        = 1'b0;
   logic [PAGE_W-1:0]   req_page_index = '0;
   logic                rsp_valid;
   logic [PAGE_W-1:0]   rsp_alloc_index;
   logic [1:0]          rsp_status;
   logic [COUNT_W-1:0]  rsp_avail_pages;
   logic                csr_we         = 1'b0;
   logic                csr_index      = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata      = '0;

   frame_board_type board;
   int              items_sent = 0;

   page_frame_allocator_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_page_index  (req_page_index),
      .rsp_valid       (rsp_valid),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_status      (rsp_status),
      .rsp_avail_pages (rsp_avail_pages),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_response(rsp_alloc_index, rsp_status, rsp_avail_pages);
         if (start && !busy) board.note_request(req_cmd, req_page_index);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("tb_page_frame_allocator_core: FAIL");
      $finish;
   end

   task automatic send_page_cmd(logic cmd, logic [PAGE_W-1:0] idx);
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_page_index = idx;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      items_sent++;
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [COUNT_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      board.set_register(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin : stimulus
      int                first;
      int                count;
      int                pick;
      int                alloc_pct;
      int                n;
      int                burst_left;
      int                roll;
      int                lo;
      int                hi;
      int                span;
      int                s;
      logic              cmd;
      logic [PAGE_W-1:0] idx;
      bit                found;

      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default window: grant, double free, top page never used
      send_page_cmd(CMD_ALLOC, '1);
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_FREE, PAGE_W'(1));
      send_page_cmd(CMD_FREE, PAGE_W'(1));
      send_page_cmd(CMD_FREE, PAGE_W'(4095));
      send_page_cmd(CMD_FREE, PAGE_W'(0));
      send_page_cmd(CMD_ALLOC, PAGE_W'(1234));

      // top of the map: fill a two-page window, then free below it
      wait_idle();
      write_csr(CSR_FIRST, COUNT_W'(4094));
      write_csr(CSR_COUNT, COUNT_W'(4096));
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_FREE, PAGE_W'(4093));
      send_page_cmd(CMD_FREE, PAGE_W'(4095));
      send_page_cmd(CMD_ALLOC, '0);

      // empty window
      wait_idle();
      write_csr(CSR_FIRST, COUNT_W'(10));
      write_csr(CSR_COUNT, COUNT_W'(10));
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_FREE, PAGE_W'(10));

      // single page window
      wait_idle();
      write_csr(CSR_FIRST, COUNT_W'(0));
      write_csr(CSR_COUNT, COUNT_W'(1));
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_FREE, PAGE_W'(0));
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_FREE, PAGE_W'(1));

      wait_idle();
      write_csr(CSR_FIRST, COUNT_W'(4095));
      write_csr(CSR_COUNT, COUNT_W'(1));
      send_page_cmd(CMD_ALLOC, '0);
      send_page_cmd(CMD_FREE, PAGE_W'(4095));

      burst_left = 0;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            first = $urandom_range(0, 4095);
            count = first + $urandom_range(1, 96);
            if (count > 4096) count = 4096;
         end else if (pick < 75) begin
            first = $urandom_range(0, 4095);
            count = 4096;
         end else if (pick < 85) begin
            first = 0;
            count = $urandom_range(1, 4096);
         end else if (pick < 92) begin
            first = 0;
            count = 4096;
         end else begin
            first = $urandom_range(1, 4095);
            count = $urandom_range(1, first);
         end
         wait_idle();
         write_csr(CSR_FIRST, COUNT_W'(first));
         write_csr(CSR_COUNT, COUNT_W'(count));

         alloc_pct = $urandom_range(25, 75);
         n = $urandom_range(20, 120);
         repeat (n) begin
            lo = int'(board.first_page);
            hi = board.page_limit();
            if ($urandom_range(0, 99) < alloc_pct) begin
               cmd = CMD_ALLOC;
               idx = PAGE_W'($urandom);
            end else begin
               cmd = CMD_FREE;
               roll = $urandom_range(0, 99);
               if (roll < 70 && lo < hi) begin
                  // pick a page in use, searching from a random point
                  span = hi - lo;
                  s = $urandom_range(0, span - 1);
                  idx = PAGE_W'(lo + s);
                  found = 1'b0;
                  for (int k = 0; k < span && !found; k++) begin
                     if (board.used_map[lo + (s + k) % span]) begin
                        idx = PAGE_W'(lo + (s + k) % span);
                        found = 1'b1;
                     end
                  end
               end else if (roll < 85 && lo < hi) begin
                  idx = PAGE_W'($urandom_range(lo, hi - 1));
               end else begin
                  idx = PAGE_W'($urandom);
               end
            end
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
            end
            burst_left--;
            send_page_cmd(cmd, idx);
         end
      end

      wait_idle();
      if (board.mismatches + board.pending() == 0) begin
         $display("tb_page_frame_allocator_core: PASS");
      end else begin
         $display("tb_page_frame_allocator_core: FAIL");
      end
      $finish;
   end
endmodule

// File: files.f
design/pfa_pkg.sv
design/pfa_ram.sv
design/page_frame_allocator_core.sv
design/pfa_checker.sv
dv/pfa_sb_pkg.sv
dv/tb_page_frame_allocator_core.sv
